// ----- rtl/hkrm_pkg.sv -----
// hkrm_pkg: shared types and constants for the hashed key to rank map.
// No dependencies; used by hkrm_table and the core in rtl/.
package hkrm_pkg;

    localparam int KEY_BYTES_DEF   = 32;
    localparam int MAX_ENTRIES_DEF = 256;
    localparam int MAX_BUCKETS_DEF = 256;

    localparam int CFG_W    = 9;
    localparam int RANK_W   = 12;
    localparam int STATUS_W = 2;

    localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = 9'd256;

    // Hash step constants: h*33 + 5 + byte.
    localparam int HASH_MUL_SHIFT = 5;
    localparam int HASH_ADD       = 5;

    localparam logic       OP_LOOKUP = 1'b0;
    localparam logic       OP_INSERT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic              kind;
        logic [7:0]        key_byte;
        logic [RANK_W-1:0] rank;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [RANK_W-1:0]   found_rank;
    } t_result;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_HEAD,
        S_LINK,
        S_FETCH,
        S_CMP
    } t_state;

endpackage

// ----- rtl/hkrm_mod_unit.sv -----
// hkrm_mod_unit: restoring remainder unit, one dividend bit per cycle.
// Depends on nothing but its parameters.
module hkrm_mod_unit #(
    parameter int DVD_W = 17,
    parameter int DIV_W = 9,
    parameter int REM_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_done,
    output logic [REM_W-1:0] o_rem
);
    localparam int STEP_W = $clog2(DVD_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DIV_W-1:0]  r_rem;
    logic [DVD_W-1:0]  r_dvd;
    logic [DIV_W-1:0]  r_div;
    logic [DIV_W:0]    n_trial;
    logic [DIV_W-1:0]  n_rem;

    always_comb begin
        n_trial = {r_rem, r_dvd[DVD_W-1]};
        if (n_trial >= {1'b0, r_div}) begin
            n_trial = n_trial - {1'b0, r_div};
        end
        n_rem = n_trial[DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[REM_W-1:0];

endmodule

// ----- rtl/hkrm_table.sv -----
// hkrm_table: bucket head memory and entry memory (key, rank, next link).
// Synchronous read with registered read data. Uses hkrm_pkg.
module hkrm_table #(
    parameter int KEY_BYTES   = hkrm_pkg::KEY_BYTES_DEF,
    parameter int MAX_ENTRIES = hkrm_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_BUCKETS = hkrm_pkg::MAX_BUCKETS_DEF,
    parameter int BW          = 8,
    parameter int EW          = 9,
    parameter int IW          = 8
) (
    input  logic                      i_clk,
    input  logic [BW-1:0]             i_head_raddr,
    input  logic                      i_head_we,
    input  logic [BW-1:0]             i_head_waddr,
    input  logic [EW-1:0]             i_head_wdata,
    output logic [EW-1:0]             o_head_q,
    input  logic [IW-1:0]             i_ent_raddr,
    input  logic                      i_ent_we,
    input  logic [IW-1:0]             i_ent_waddr,
    input  logic [KEY_BYTES*8-1:0]    i_ent_key,
    input  logic [hkrm_pkg::RANK_W-1:0] i_ent_rank,
    input  logic [EW-1:0]             i_ent_next,
    output logic [KEY_BYTES*8-1:0]    o_ent_key,
    output logic [hkrm_pkg::RANK_W-1:0] o_ent_rank,
    output logic [EW-1:0]             o_ent_next
);
    localparam int ENT_W = KEY_BYTES * 8 + hkrm_pkg::RANK_W + EW;

    logic [EW-1:0]    r_head_mem [MAX_BUCKETS];
    logic [ENT_W-1:0] r_ent_mem  [MAX_ENTRIES];
    logic [EW-1:0]    r_head_q;
    logic [ENT_W-1:0] r_ent_q;

    always_ff @(posedge i_clk) begin
        if (i_head_we) begin
            r_head_mem[i_head_waddr] <= i_head_wdata;
        end
        r_head_q <= r_head_mem[i_head_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ent_we) begin
            r_ent_mem[i_ent_waddr] <= {i_ent_key, i_ent_rank, i_ent_next};
        end
        r_ent_q <= r_ent_mem[i_ent_raddr];
    end

    assign o_head_q   = r_head_q;
    assign o_ent_next = r_ent_q[EW-1:0];
    assign o_ent_rank = r_ent_q[EW +: hkrm_pkg::RANK_W];
    assign o_ent_key  = r_ent_q[ENT_W-1 -: KEY_BYTES*8];

endmodule

// ----- rtl/hashed_key_to_rank_map_core.sv -----
// hashed_key_to_rank_map_core: top level of the chained hash map.
// Uses hkrm_pkg, hkrm_mod_unit and hkrm_table.
//
// Channel   Direction  Handshake                      Payload
// item      in         i_start & !o_busy              i_item (hkrm_pkg::t_in_item)
// result    out        o_result_valid (1-cycle strobe) o_result (hkrm_pkg::t_result)
// config    in         i_cfg_valid & o_cfg_ready      i_cfg_data (bucket_count)
//
// Flow: each byte transfer starts the remainder unit, which works one bit
// per cycle through DVD_W bits (DVD_W = hash width + 9); busy stays high until
// the remainder is registered, so a byte is not taken before the last one's hash.
// After the last byte the chain walk keeps busy high through head read, link and
// fetch, then a compare and another fetch per entry visited, the fetch left out
// when the walk ends on a match. An insert writes in the final fetch cycle;
// the result strobes as busy drops. After reset a clearing pass empties all
// MAX_BUCKETS bucket heads; busy stays high during it. Config is always ready.
// The receiver cannot stall: the result is shown for exactly one cycle.
module hashed_key_to_rank_map_core #(
    parameter int KEY_BYTES   = hkrm_pkg::KEY_BYTES_DEF,
    parameter int MAX_ENTRIES = hkrm_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_BUCKETS = hkrm_pkg::MAX_BUCKETS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  hkrm_pkg::t_in_item            i_item,
    output logic                          o_result_valid,
    output hkrm_pkg::t_result             o_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [hkrm_pkg::CFG_W-1:0]    i_cfg_data
);
    // hash / bucket index width, bucket count width
    localparam int BW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int NW    = $clog2(MAX_BUCKETS + 1);
    localparam int DVD_W = BW + 9;
    // link width (index + 1, zero = null), entry index width
    localparam int EW    = $clog2(MAX_ENTRIES + 1);
    localparam int IW    = $clog2(MAX_ENTRIES);
    localparam int CW    = $clog2(KEY_BYTES + 1);
    localparam int KW    = KEY_BYTES * 8;

    hkrm_pkg::t_state r_state, n_state;

    logic [hkrm_pkg::CFG_W-1:0]  r_cfg;
    logic [CW-1:0]               r_cnt;
    logic [BW-1:0]               r_hash;
    logic                        r_kind;
    logic [hkrm_pkg::RANK_W-1:0] r_rank;
    logic [KW-1:0]               r_key;
    logic [EW-1:0]               r_link;
    logic [EW-1:0]               r_head;
    logic [EW-1:0]               r_used;
    logic [BW-1:0]               r_clr;
    logic                        r_out_valid;
    hkrm_pkg::t_result           r_out;

    logic              accept;
    logic [NW-1:0]     eff_n;
    logic [DVD_W-1:0]  dividend;
    logic [BW-1:0]     h_prev;
    logic              mod_done;
    logic [BW-1:0]     mod_rem;
    logic              last_byte;

    logic [EW-1:0]     head_q;
    logic [KW-1:0]     ent_key;
    logic [hkrm_pkg::RANK_W-1:0] ent_rank;
    logic [EW-1:0]     ent_next;

    logic              key_match;
    logic              finish;
    logic              hit;
    logic              full;
    logic              ins_ok;
    logic              head_we;
    logic [BW-1:0]     head_waddr;
    logic [EW-1:0]     head_wdata;
    logic              ent_we;
    logic [IW-1:0]     ent_raddr;
    logic [EW-1:0]     link_m1;

    assign accept      = i_start && (r_state == hkrm_pkg::S_IDLE);
    assign o_busy      = (r_state != hkrm_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Bucket count in use: zero acts as one, saturate at MAX_BUCKETS.
    always_comb begin
        if (r_cfg == '0) begin
            eff_n = NW'(1);
        end else if (32'(r_cfg) > 32'(MAX_BUCKETS)) begin
            eff_n = NW'(MAX_BUCKETS);
        end else begin
            eff_n = NW'(r_cfg);
        end
    end

    // h*33 + 5 + byte; the hash restarts at zero on the first byte
    assign h_prev   = (r_cnt == '0) ? '0 : r_hash;
    assign dividend = (DVD_W'(h_prev) << hkrm_pkg::HASH_MUL_SHIFT) + DVD_W'(h_prev)
                    + DVD_W'(hkrm_pkg::HASH_ADD) + DVD_W'(i_item.key_byte);

    hkrm_mod_unit #(
        .DVD_W (DVD_W),
        .DIV_W (NW),
        .REM_W (BW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_dividend (dividend),
        .i_divisor  (eff_n),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign last_byte = (r_cnt == CW'(KEY_BYTES - 1));

    // Chain walk decisions
    assign link_m1   = r_link - 1'b1;
    assign ent_raddr = link_m1[IW-1:0];
    assign key_match = (ent_key == r_key);
    assign hit       = (r_state == hkrm_pkg::S_CMP) && key_match;
    assign finish    = ((r_state == hkrm_pkg::S_FETCH) && (r_link == '0)) || hit;
    assign full      = (r_used >= EW'(MAX_ENTRIES));
    assign ins_ok    = finish && (r_kind == hkrm_pkg::OP_INSERT) && !hit && !full;

    // Memory write control: clearing pass, or prepend on a good insert
    always_comb begin
        head_we    = 1'b0;
        head_waddr = r_hash;
        head_wdata = r_used + 1'b1;
        ent_we     = 1'b0;
        case (r_state)
            hkrm_pkg::S_CLEAR: begin
                head_we    = 1'b1;
                head_waddr = r_clr;
                head_wdata = '0;
            end
            default: begin
                head_we = ins_ok;
                ent_we  = ins_ok;
            end
        endcase
    end

    hkrm_table #(
        .KEY_BYTES   (KEY_BYTES),
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_BUCKETS (MAX_BUCKETS),
        .BW          (BW),
        .EW          (EW),
        .IW          (IW)
    ) u_table (
        .i_clk        (i_clk),
        .i_head_raddr (r_hash),
        .i_head_we    (head_we),
        .i_head_waddr (head_waddr),
        .i_head_wdata (head_wdata),
        .o_head_q     (head_q),
        .i_ent_raddr  (ent_raddr),
        .i_ent_we     (ent_we),
        .i_ent_waddr  (r_used[IW-1:0]),
        .i_ent_key    (r_key),
        .i_ent_rank   (r_rank),
        .i_ent_next   (r_head),
        .o_ent_key    (ent_key),
        .o_ent_rank   (ent_rank),
        .o_ent_next   (ent_next)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hkrm_pkg::S_CLEAR: begin
                if (r_clr == BW'(MAX_BUCKETS - 1)) n_state = hkrm_pkg::S_IDLE;
            end
            hkrm_pkg::S_IDLE: begin
                if (i_start) n_state = hkrm_pkg::S_HASH;
            end
            hkrm_pkg::S_HASH: begin
                if (mod_done) n_state = last_byte ? hkrm_pkg::S_HEAD : hkrm_pkg::S_IDLE;
            end
            hkrm_pkg::S_HEAD:  n_state = hkrm_pkg::S_LINK;
            hkrm_pkg::S_LINK:  n_state = hkrm_pkg::S_FETCH;
            hkrm_pkg::S_FETCH: begin
                n_state = (r_link == '0) ? hkrm_pkg::S_IDLE : hkrm_pkg::S_CMP;
            end
            hkrm_pkg::S_CMP: begin
                n_state = key_match ? hkrm_pkg::S_IDLE : hkrm_pkg::S_FETCH;
            end
            default: n_state = hkrm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hkrm_pkg::S_CLEAR;
            r_cfg       <= hkrm_pkg::BUCKET_COUNT_RST;
            r_cnt       <= '0;
            r_used      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= finish;
            if (i_cfg_valid) r_cfg <= i_cfg_data;
            if (r_state == hkrm_pkg::S_CLEAR) r_clr <= r_clr + 1'b1;
            if (mod_done) r_cnt <= last_byte ? '0 : r_cnt + 1'b1;
            if (ins_ok) r_used <= r_used + 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (r_cnt == '0) r_kind <= i_item.kind;
            r_rank <= i_item.rank;
            r_key[32'(r_cnt) * 8 +: 8] <= i_item.key_byte;
        end
        if (mod_done) r_hash <= mod_rem;
        if (r_state == hkrm_pkg::S_LINK) begin
            r_link <= head_q;
            r_head <= head_q;
        end
        if ((r_state == hkrm_pkg::S_CMP) && !key_match) r_link <= ent_next;
        if (finish) begin
            r_out.found_rank <= '0;
            if (r_kind == hkrm_pkg::OP_LOOKUP) begin
                r_out.status <= hit ? hkrm_pkg::ST_OK : hkrm_pkg::ST_NOT_FOUND;
                if (hit) r_out.found_rank <= ent_rank;
            end else if (hit) begin
                r_out.status <= hkrm_pkg::ST_DUPLICATE;
            end else if (full) begin
                r_out.status <= hkrm_pkg::ST_FULL;
            end else begin
                r_out.status <= hkrm_pkg::ST_OK;
            end
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    a_result_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == hkrm_pkg::S_IDLE))
        else $error("result strobe outside end of chain walk");

    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= EW'(MAX_ENTRIES))
        else $error("entry pool count overflow");

    a_rank_only_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status != hkrm_pkg::ST_OK)) |-> (r_out.found_rank == '0))
        else $error("nonzero rank without a hit");

    a_insert_when_idle_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ins_ok |=> (r_state == hkrm_pkg::S_IDLE) && r_out_valid)
        else $error("insert not followed by result");

endmodule

// ----- tb/hashed_key_to_rank_map_checker.sv -----
// Checker for hashed_key_to_rank_map_core: watches the item, config and result
// channels, predicts each result and compares it. Depends on hkrm_pkg.
module hashed_key_to_rank_map_checker
    import hkrm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  t_in_item            i_item,
    input  logic                i_result_valid,
    input  t_result             i_result,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [CFG_W-1:0]    i_cfg_data,
    output int                  o_pending,
    output int                  o_errors
);

    localparam int KB = KEY_BYTES_DEF;

    // table image; heads and links hold entry index + 1, zero is empty
    int                     head_link [MAX_BUCKETS_DEF];
    logic [8*KB-1:0]        stored_key [MAX_ENTRIES_DEF];
    logic [RANK_W-1:0]      stored_rank [MAX_ENTRIES_DEF];
    int                     next_link [MAX_ENTRIES_DEF];
    int                     used_count;
    logic [8*KB-1:0]        key_acc;
    int                     hash_val;
    int                     byte_idx;
    logic                   op_kind;
    logic [CFG_W-1:0]       buckets_cfg;
    t_result                expected_results [$];

    assign o_pending = expected_results.size();

    task automatic report(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        o_errors++;
    endtask

    task automatic hash_byte(input t_in_item it);
        int n;
        int link;
        int hit;
        t_result r;
        n = (buckets_cfg == 0) ? 1 : (buckets_cfg > MAX_BUCKETS_DEF) ? MAX_BUCKETS_DEF
                                                                     : int'(buckets_cfg);
        if (byte_idx == 0) begin
            op_kind = it.kind;
            hash_val = 0;
        end
        hash_val = (hash_val * 33 + 5 + int'(it.key_byte)) % n;
        key_acc[8*byte_idx +: 8] = it.key_byte;
        byte_idx++;
        if (byte_idx < KB) return;
        // last byte: walk the chain
        hit = 0;
        link = head_link[hash_val];
        while (link != 0 && hit == 0) begin
            if (stored_key[link-1] == key_acc) hit = link;
            else link = next_link[link-1];
        end
        r.found_rank = '0;
        if (op_kind == OP_LOOKUP) begin
            if (hit != 0) begin
                r.status = ST_OK;
                r.found_rank = stored_rank[hit-1];
            end else begin
                r.status = ST_NOT_FOUND;
            end
        end else if (hit != 0) begin
            r.status = ST_DUPLICATE;
        end else if (used_count >= MAX_ENTRIES_DEF) begin
            r.status = ST_FULL;
        end else begin
            stored_key[used_count] = key_acc;
            stored_rank[used_count] = it.rank;
            next_link[used_count] = head_link[hash_val];
            head_link[hash_val] = used_count + 1;
            used_count++;
            r.status = ST_OK;
        end
        expected_results.push_back(r);
        byte_idx = 0;
        hash_val = 0;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            foreach (head_link[b]) head_link[b] = 0;
            used_count = 0;
            key_acc = '0;
            hash_val = 0;
            byte_idx = 0;
            op_kind = OP_LOOKUP;
            buckets_cfg = BUCKET_COUNT_RST;
            expected_results.delete();
            o_errors = 0;
        end else begin
            if (i_result_valid) begin
                if (expected_results.size() == 0) begin
                    report("unexpected result, status", i_result.status, -1);
                end else begin
                    want = expected_results.pop_front();
                    if (i_result.status !== want.status)
                        report("status", i_result.status, want.status);
                    if (i_result.found_rank !== want.found_rank)
                        report("found_rank", i_result.found_rank, want.found_rank);
                end
            end
            // a byte taken at the same edge as a config write still sees the old count
            if (i_start && !i_busy) hash_byte(i_item);
            if (i_cfg_valid && i_cfg_ready) buckets_cfg = i_cfg_data;
        end
    end

endmodule

// ----- tb/hashed_key_to_rank_map_core_test.sv -----
// Top of the hashed_key_to_rank_map_core testbench: clock, reset, stimulus
// and verdict. Depends on hkrm_pkg, the core and hashed_key_to_rank_map_checker.
module hashed_key_to_rank_map_core_test;
    import hkrm_pkg::*;

    localparam int KB = KEY_BYTES_DEF;
    // cycles of quiet that cover any byte still in the hash unit
    localparam int SETTLE = 60;
    // no transfer for this long means a hang; the longest correct quiet
    // stretch is the clearing pass or a full chain walk
    localparam int WATCHDOG_LIMIT = 20000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    t_in_item           i_item = '0;
    logic               o_result_valid;
    t_result            o_result;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CFG_W-1:0]   i_cfg_data = '0;

    int                 pending_results;
    int                 error_count;
    int                 idle_pct;
    int                 quiet_cycles = 0;
    logic [8*KB-1:0]    key_pool [$];

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    hashed_key_to_rank_map_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    hashed_key_to_rank_map_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_busy         (o_busy),
        .i_item         (i_item),
        .i_result_valid (o_result_valid),
        .i_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_pending      (pending_results),
        .o_errors       (error_count)
    );

    // Watchdog: counts cycles with no transfer on any channel.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || (i_cfg_valid && o_cfg_ready) || o_result_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // One byte transfer. Busy is sampled at the falling edge, where it is
    // stable, so the transfer is known to happen at the next rising edge.
    task automatic send_byte(input logic kind, input logic [7:0] b, input logic [11:0] rk);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item <= '{kind: kind, key_byte: b, rank: rk};
        forever begin
            @(negedge i_clk);
            if (!o_busy) break;
        end
        @(posedge i_clk);
    endtask

    // Streams bytes lo..hi-1 of a key; kind and rank only matter on the
    // first and last byte, elsewhere they carry noise.
    task automatic send_key(input logic kind, input logic [8*KB-1:0] k, input logic [11:0] rk,
                            input int lo, input int hi);
        for (int i = lo; i < hi; i++)
            send_byte((i == 0) ? kind : 1'($urandom), k[8*i +: 8],
                      (i == KB-1) ? rk : 12'($urandom));
    endtask

    // Pause the sender until every result is in and the core is quiet.
    task automatic drain;
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic write_buckets(input logic [CFG_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        forever begin
            @(negedge i_clk);
            if (o_cfg_ready) break;
        end
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [8*KB-1:0] rand_key;
        logic [8*KB-1:0] k;
        for (int i = 0; i < KB; i += 4) k[8*i +: 32] = $urandom;
        return k;
    endfunction

    function automatic logic [11:0] rand_rank;
        case ($urandom_range(9))
            0: return 12'd0;
            1: return 12'hFFF;
            default: return 12'($urandom);
        endcase
    endfunction

    // Mostly keys seen before, so lookups hit and inserts collide.
    task automatic random_key_op;
        logic [8*KB-1:0] k;
        logic kind;
        kind = 1'($urandom);
        if (key_pool.size() != 0 && $urandom_range(99) < 70)
            k = key_pool[$urandom_range(key_pool.size() - 1)];
        else
            k = rand_key();
        if (kind == OP_INSERT) key_pool.push_back(k);
        send_key(kind, k, rand_rank(), 0, KB);
    endtask

    initial begin
        logic [8*KB-1:0] k;
        logic [CFG_W-1:0] bucket_settings [7];
        int phase_idle [4];
        bucket_settings = '{9'd1, 9'd0, 9'd511, 9'd256, 9'd7, 9'd255, 9'd100};
        phase_idle = '{0, 51, 11, 0};
        idle_pct = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero and all-ones keys, rank extremes, hit, miss, duplicate.
        send_key(OP_INSERT, '0, 12'd0, 0, KB);
        send_key(OP_LOOKUP, '0, 12'hFFF, 0, KB);
        send_key(OP_INSERT, '1, 12'hFFF, 0, KB);
        send_key(OP_LOOKUP, '1, 12'd0, 0, KB);
        send_key(OP_INSERT, '0, 12'd5, 0, KB);
        k = rand_key();
        send_key(OP_LOOKUP, k, 12'd0, 0, KB);

        // Bucket count changed halfway through a key.
        drain();
        write_buckets(9'd1);
        send_key(OP_INSERT, k, 12'd77, 0, KB / 2);
        drain();
        write_buckets(9'd256);
        send_key(OP_INSERT, k, 12'd77, KB / 2, KB);
        send_key(OP_LOOKUP, k, 12'd0, 0, KB);
        key_pool.push_back(k);

        // Random phases over bucket settings and sender idling.
        for (int p = 0; p < 7; p++) begin
            drain();
            write_buckets(bucket_settings[p]);
            for (int q = 0; q < 4; q++) begin
                idle_pct = phase_idle[q];
                repeat (1 + q % 2) random_key_op();
            end
        end
        idle_pct = 0;

        // Duplicate insert and closing lookups.
        drain();
        write_buckets(9'd256);
        send_key(OP_INSERT, key_pool[0], 12'd1, 0, KB);
        send_key(OP_LOOKUP, key_pool[$], 12'd0, 0, KB);
        send_key(OP_LOOKUP, rand_key(), 12'd0, 0, KB);

        drain();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
